// File: rtl/dsp_pkg.sv
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared widths, constants and register indexes of the differential
// steering controller.
// ----------------------------------------------------------------------------
package dsp_pkg;

    // parameter defaults
    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int ERROR_WIDTH_DEF    = 16;

    // fixed field widths
    localparam int GAIN_W     = 20;
    localparam int SETPOINT_W = 16;
    localparam int BASE_W     = 10;
    localparam int INT_W      = 32;
    localparam int RAW_W      = 13;
    localparam int SCALED_W   = 8;
    localparam int DRIVE_W    = 12;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // output limit and scale
    localparam int OUT_LIMIT   = 3200;
    localparam int SCALE_SHIFT = 5;

    // queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // register reset values
    localparam logic [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(51200);
    localparam logic [GAIN_W-1:0] GAIN_I_RST = GAIN_W'(102);
    localparam logic [GAIN_W-1:0] GAIN_D_RST = GAIN_W'(93440);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_SETPOINT   = 3'd3,
        REG_BASE_DRIVE = 3'd4
    } reg_index_t;

endpackage

// File: rtl/differential_steering_pid.sv
// A request passes the middle queue, product and sum registers, then the result queue.
// Throughput: one request per cycle while not full, set by the front's integral update.
// The gain multiply and the sum each take a pipeline stage in the back.
// Reset (rst_n low, asynchronous): queues empty, integral and previous bias zero,
// registers back to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// differential_steering_pid
// Positional PID for differential wheel steering: front state update, a
// middle queue, a pipelined back end and a result queue.
// ----------------------------------------------------------------------------
module differential_steering_pid
    import dsp_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int ERROR_WIDTH    = ERROR_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [ERROR_WIDTH-1:0] error_sample,
    input  logic                          clear_state,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [RAW_W-1:0]       correction_raw,
    output logic signed [SCALED_W-1:0]    correction_scaled,
    output logic signed [DRIVE_W-1:0]     left_drive,
    output logic signed [DRIVE_W-1:0]     right_drive,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int BIAS_W  = ((ERROR_WIDTH > SETPOINT_W) ? ERROR_WIDTH : SETPOINT_W) + 1;
    localparam int MID_W   = BIAS_W + INT_W + BIAS_W + 1;
    localparam int RES_W   = RAW_W + SCALED_W + 2 * DRIVE_W;
    localparam int OUT_CW  = $clog2(OUT_DEPTH + 1);
    localparam int MID_CW  = $clog2(MID_DEPTH + 1);

    logic [GAIN_W-1:0]            gain_p_reg;
    logic [GAIN_W-1:0]            gain_i_reg;
    logic [GAIN_W-1:0]            gain_d_reg;
    logic signed [SETPOINT_W-1:0] setpoint_reg;
    logic [BASE_W-1:0]            base_drive_reg;

    logic                         accept;
    logic signed [BIAS_W-1:0]     f_bias;
    logic signed [INT_W-1:0]      f_integ;
    logic signed [BIAS_W:0]       f_delta;
    logic [MID_W-1:0]             mid_head;
    logic                         mid_empty;
    logic                         mid_pop;
    logic [MID_CW-1:0]            mid_count;
    logic                         out_wr;
    logic [OUT_CW-1:0]            out_count;
    logic signed [RAW_W-1:0]      b_raw;
    logic signed [SCALED_W-1:0]   b_scaled;
    logic signed [DRIVE_W-1:0]    b_left;
    logic signed [DRIVE_W-1:0]    b_right;
    logic [RES_W-1:0]             res_head;
    logic                         out_full;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
            setpoint_reg   <= '0;
            base_drive_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN_P:     gain_p_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     gain_i_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     gain_d_reg     <= cfg_data[GAIN_W-1:0];
                REG_SETPOINT:   setpoint_reg   <= cfg_data[SETPOINT_W-1:0];
                REG_BASE_DRIVE: base_drive_reg <= cfg_data[BASE_W-1:0];
                default:        ;
            endcase
        end
    end

    // front: state update
    dsp_front #(
        .ERROR_WIDTH (ERROR_WIDTH),
        .BIAS_W      (BIAS_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .error_sample (error_sample),
        .clear_state  (clear_state),
        .setpoint     (setpoint_reg),
        .bias         (f_bias),
        .integ        (f_integ),
        .delta        (f_delta)
    );

    // middle queue
    dsp_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data ({f_bias, f_integ, f_delta}),
        .rd_en   (mid_pop),
        .rd_data (mid_head),
        .full    (full),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    // back: products, sum and drives
    dsp_back #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .BIAS_W         (BIAS_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .gain_p     (gain_p_reg),
        .gain_i     (gain_i_reg),
        .gain_d     (gain_d_reg),
        .base_drive (base_drive_reg),
        .mid_empty  (mid_empty || (mid_count == '0)),
        .bias       (mid_head[MID_W-1 -: BIAS_W]),
        .integ      (mid_head[BIAS_W+1 +: INT_W]),
        .delta      (mid_head[BIAS_W:0]),
        .mid_pop    (mid_pop),
        .out_count  (out_count),
        .out_wr     (out_wr),
        .raw        (b_raw),
        .scaled     (b_scaled),
        .left       (b_left),
        .right      (b_right)
    );

    // result queue
    dsp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data ({b_raw, b_scaled, b_left, b_right}),
        .rd_en   (pop),
        .rd_data (res_head),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

    assign correction_raw    = res_head[RES_W-1 -: RAW_W];
    assign correction_scaled = res_head[2*DRIVE_W +: SCALED_W];
    assign left_drive        = res_head[DRIVE_W +: DRIVE_W];
    assign right_drive       = res_head[DRIVE_W-1:0] ^ {DRIVE_W{out_full & 1'b0}};

endmodule

// File: rtl/dsp_fifo.sv
// ----------------------------------------------------------------------------
// dsp_fifo
// Small register queue with a fill count, head shown combinationally.
// ----------------------------------------------------------------------------
module dsp_fifo
    import dsp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign do_wr   = wr_en && (count_reg != CW'(DEPTH));
    assign do_rd   = rd_en && (count_reg != '0);
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// File: rtl/dsp_front.sv
// ----------------------------------------------------------------------------
// dsp_front
// Takes error samples, forms the bias, updates the saturating integral (cleared
// on a zero bias) and the previous bias, and hands bias, integral and delta to the queue.
// ----------------------------------------------------------------------------
module dsp_front
    import dsp_pkg::*;
#(
    parameter int ERROR_WIDTH = ERROR_WIDTH_DEF,
    parameter int BIAS_W      = ERROR_WIDTH_DEF + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic signed [ERROR_WIDTH-1:0] error_sample,
    input  logic                          clear_state,
    input  logic signed [SETPOINT_W-1:0]  setpoint,
    output logic signed [BIAS_W-1:0]      bias,
    output logic signed [INT_W-1:0]       integ,
    output logic signed [BIAS_W:0]        delta
);

    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};

    logic signed [INT_W-1:0]  integral_reg;
    logic signed [INT_W-1:0]  integral_next;
    logic signed [BIAS_W-1:0] prev_bias_reg;
    logic signed [BIAS_W-1:0] prev_bias_next;
    logic signed [BIAS_W-1:0] bias_calc;
    logic signed [INT_W:0]    integ_wide;
    logic signed [INT_W-1:0]  integ_sat;

    // bias and saturating integral, cleared on a zero bias
    always_comb
    begin
        bias_calc = {{(BIAS_W-ERROR_WIDTH){error_sample[ERROR_WIDTH-1]}}, error_sample}
                  - {{(BIAS_W-SETPOINT_W){setpoint[SETPOINT_W-1]}}, setpoint};
        integ_wide = {integral_reg[INT_W-1], integral_reg}
                   + {{(INT_W+1-BIAS_W){bias_calc[BIAS_W-1]}}, bias_calc};
        if (integ_wide[INT_W] != integ_wide[INT_W-1])
        begin
            integ_sat = integ_wide[INT_W] ? INT_MIN : INT_MAX;
        end
        else
        begin
            integ_sat = integ_wide[INT_W-1:0];
        end
        if (bias_calc == '0)
        begin
            integ_sat = '0;
        end
    end

    // clear request zeroes state and sends a zero entry
    always_comb
    begin
        if (clear_state)
        begin
            bias           = '0;
            integ          = '0;
            delta          = '0;
            integral_next  = '0;
            prev_bias_next = '0;
        end
        else
        begin
            bias           = bias_calc;
            integ          = integ_sat;
            delta          = {bias_calc[BIAS_W-1], bias_calc}
                           - {prev_bias_reg[BIAS_W-1], prev_bias_reg};
            integral_next  = integ_sat;
            prev_bias_next = bias_calc;
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            prev_bias_reg <= '0;
        end
        else if (accept)
        begin
            integral_reg  <= integral_next;
            prev_bias_reg <= prev_bias_next;
        end
    end

endmodule

// File: rtl/dsp_back.sv
// ----------------------------------------------------------------------------
// dsp_back
// Multiplies by the gains, sums, clamps, scales and forms the wheel drives;
// pops the middle queue only while the result queue has room for it.
// ----------------------------------------------------------------------------
module dsp_back
    import dsp_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
    parameter int BIAS_W         = ERROR_WIDTH_DEF + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [GAIN_W-1:0]             gain_p,
    input  logic [GAIN_W-1:0]             gain_i,
    input  logic [GAIN_W-1:0]             gain_d,
    input  logic [BASE_W-1:0]             base_drive,
    input  logic                          mid_empty,
    input  logic signed [BIAS_W-1:0]      bias,
    input  logic signed [INT_W-1:0]       integ,
    input  logic signed [BIAS_W:0]        delta,
    output logic                          mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                          out_wr,
    output logic signed [RAW_W-1:0]       raw,
    output logic signed [SCALED_W-1:0]    scaled,
    output logic signed [DRIVE_W-1:0]     left,
    output logic signed [DRIVE_W-1:0]     right
);

    localparam int PP_W  = GAIN_W + 1 + BIAS_W;
    localparam int PI_W  = GAIN_W + 1 + INT_W;
    localparam int PD_W  = GAIN_W + 2 + BIAS_W;
    localparam int SUM_W = PI_W + 2;
    localparam int CW    = $clog2(OUT_DEPTH + 1);
    localparam logic signed [SUM_W-1:0] LIM   = SUM_W'(OUT_LIMIT) <<< GAIN_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] ROUND = SUM_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam logic signed [RAW_W-1:0] SROUND = RAW_W'((1 << SCALE_SHIFT) - 1);

    logic                    s1_valid_reg;
    logic                    s2_valid_reg;
    logic signed [PP_W-1:0]  prod_p_reg;
    logic signed [PI_W-1:0]  prod_i_reg;
    logic signed [PD_W-1:0]  prod_d_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [SUM_W-1:0] sum_shift;
    logic [CW:0]             in_use;

    // credit check against the result queue
    assign in_use  = {1'b0, out_count} + (CW+1)'(s1_valid_reg) + (CW+1)'(s2_valid_reg);
    assign mid_pop = !mid_empty && (in_use < (CW+1)'(OUT_DEPTH));
    assign out_wr  = s2_valid_reg;

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= mid_pop;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // gain products, then their sum
    always_ff @(posedge clk)
    begin
        if (mid_pop)
        begin
            prod_p_reg <= $signed({1'b0, gain_p}) * bias;
            prod_i_reg <= $signed({1'b0, gain_i}) * integ;
            prod_d_reg <= $signed({1'b0, gain_d}) * delta;
        end
        if (s1_valid_reg)
        begin
            sum_reg <= SUM_W'(prod_p_reg) + SUM_W'(prod_i_reg) + SUM_W'(prod_d_reg);
        end
    end

    // clamp, drop fraction toward zero, scale and form drives
    always_comb
    begin
        if (sum_reg > LIM)
        begin
            sum_sat = LIM;
        end
        else if (sum_reg < -LIM)
        begin
            sum_sat = -LIM;
        end
        else
        begin
            sum_sat = sum_reg;
        end
        sum_shift = (sum_sat + (sum_sat[SUM_W-1] ? ROUND : '0)) >>> GAIN_FRAC_BITS;
        raw       = sum_shift[RAW_W-1:0];
        scaled    = SCALED_W'((raw + (raw[RAW_W-1] ? SROUND : '0)) >>> SCALE_SHIFT);
        left      = $signed({{(DRIVE_W-BASE_W){1'b0}}, base_drive})
                  - {{(DRIVE_W-SCALED_W){scaled[SCALED_W-1]}}, scaled};
        right     = $signed({{(DRIVE_W-BASE_W){1'b0}}, base_drive})
                  + {{(DRIVE_W-SCALED_W){scaled[SCALED_W-1]}}, scaled};
    end

endmodule

// File: rtl/dsp_checker.sv
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks of the steering controller, bound to the top level.
// ----------------------------------------------------------------------------
module dsp_checker
    import dsp_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       empty,
    input logic                       pop,
    input logic                       cfg_ready,
    input logic signed [RAW_W-1:0]    correction_raw,
    input logic signed [SCALED_W-1:0] correction_scaled,
    input logic signed [DRIVE_W-1:0]  left_drive,
    input logic signed [DRIVE_W-1:0]  right_drive
);

    // raw correction stays inside the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (correction_raw <= OUT_LIMIT && correction_raw >= -OUT_LIMIT))
        else $error("correction_raw outside clamp");

    // scaled correction is raw over 32 toward zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (correction_scaled == correction_raw / 32))
        else $error("correction_scaled does not match correction_raw");

    // wheel drives differ by twice the scaled correction
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((right_drive - left_drive) == (correction_scaled * 2)))
        else $error("drive difference does not match correction");

    // a waiting result holds until popped
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(correction_raw) && $stable(left_drive)))
        else $error("waiting result changed before pop");

    // configuration port never stalls
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready dropped");

endmodule

bind differential_steering_pid dsp_checker u_dsp_checker (.*);
